/* hdl/cbcrt_pkg.sv */
// Shared constants for the checkerboard corner ring test.
`default_nettype none
package cbcrt_pkg;

	// ring geometry
	localparam int RING_LEN     = 16;
	localparam int HALF_RING    = RING_LEN / 2;
	localparam int PIX_W        = 8;
	localparam int CORNER_SWAPS = 4;

	// derived widths
	localparam int SUM_W  = PIX_W + $clog2(RING_LEN);   // 12
	localparam int PSUM_W = PIX_W + 2;                  // sum of four pixels
	localparam int HI_W   = PIX_W + 1;                  // mean + gate
	localparam int LO_W   = PIX_W + 2;                  // signed mean - gate
	localparam int CNT_W  = $clog2(RING_LEN) + 1;       // 0..16
	localparam int HCNT_W = $clog2(HALF_RING) + 1;      // 0..8

	// stream word widths
	localparam int RING_W = HALF_RING * PIX_W;          // 64
	localparam int IN_W   = PIX_W + 2 * RING_W;         // 136, whole bytes
	localparam int OUT_W  = 8;                          // 7 bits used, padded

	// gate register
	localparam int          GATE_W     = 8;
	localparam logic [7:0]  GATE_RESET = 8'd10;

	typedef logic [PIX_W-1:0] pix_t;

endpackage
`default_nettype wire

/* hdl/checkerboard_corner_ring_test_top.sv */
// Checkerboard corner ring test: five stage pipeline, one window per clock.
//
// Input stream s_axis: one word per image window, the center pixel and the
// sixteen pixels of the radius-3 ring. Output stream m_axis: one word per
// input word, in order, with the corner flag, the flat-center flag and the
// hysteresis transition count around the ring.
// The gate register (band half width around the ring mean) is written with
// cfg_we / cfg_wdata while the pipeline is empty; the user must keep to this,
// as the block itself does not enforce it; the gate resets to 10. An accepted
// word moves through the stage registers in order and is valid on m_axis once
// in the last. Throughput is one word per clock unless m_axis stalls; the stages
// are the ring sum tree, mean and thresholds, per-pixel classification, and
// two halves of the hysteresis walk (eight ring pixels each).
// All stages advance together whenever the output register is empty or
// being taken, so s_axis_tready drops only while m_axis holds a word that
// the receiver stalls; nothing is lost or repeated across a stall.
// Asynchronous reset empties the pipeline and restores the gate register.
`default_nettype none
module checkerboard_corner_ring_test_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// gate register write
	input  wire logic                        cfg_we,
	input  wire logic [cbcrt_pkg::GATE_W-1:0] cfg_wdata,
	// input windows
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// [7:0] center_pixel, [71:8] ring_low, [135:72] ring_high
	input  wire logic [cbcrt_pkg::IN_W-1:0]  s_axis_tdata,
	// results
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// [0] is_corner, [1] center_flat, [6:2] transition_count, [7] zero
	output logic [cbcrt_pkg::OUT_W-1:0]      m_axis_tdata
);
	import cbcrt_pkg::*;

	logic adv;
	logic [GATE_W-1:0] gate_q;

	// stage 1: pixels and partial sums
	logic v_s1;
	pix_t px_s1 [RING_LEN];
	pix_t center_s1;
	logic [PSUM_W-1:0] psum_s1 [4];

	// stage 2: mean and thresholds
	logic v_s2;
	pix_t px_s2 [RING_LEN];
	pix_t center_s2;
	pix_t mean_s2;
	logic [HI_W-1:0] hi_s2;
	logic signed [LO_W-1:0] lo_s2;

	// stage 3: classification
	logic v_s3;
	logic [RING_LEN-1:0] below_s3, above_s3;
	logic up0_s3, flat_s3;

	// stage 4: first half of the walk
	logic v_s4;
	logic [HALF_RING-1:0] below_s4, above_s4;
	logic up_s4, flat_s4;
	logic [HCNT_W-1:0] cnt_s4;

	// stage 5: output register
	logic v_s5;
	logic corner_s5, flat_s5;
	logic [CNT_W-1:0] cnt_s5;

	// whole pipe moves when the output slot is free
	assign adv           = !v_s5 || m_axis_tready;
	assign s_axis_tready = adv;

	// gate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q <= GATE_RESET;
		end else if (cfg_we) begin
			gate_q <= cfg_wdata;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: unpack ring and sum groups of four
	pix_t px_in [RING_LEN];
	logic [PSUM_W-1:0] psum_in [4];
	always_comb begin
		for (int k = 0; k < RING_LEN; k++) begin
			px_in[k] = s_axis_tdata[PIX_W + k*PIX_W +: PIX_W];
		end
		for (int g = 0; g < 4; g++) begin
			psum_in[g] = PSUM_W'(px_in[4*g]) + PSUM_W'(px_in[4*g+1])
				+ PSUM_W'(px_in[4*g+2]) + PSUM_W'(px_in[4*g+3]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1     <= px_in;
			psum_s1   <= psum_in;
			center_s1 <= s_axis_tdata[PIX_W-1:0];
		end
	end

	// stage 2: total, mean = sum/16, thresholds
	logic [SUM_W-1:0] sum_w;
	pix_t mean_w;
	assign sum_w  = SUM_W'(psum_s1[0]) + SUM_W'(psum_s1[1])
		+ SUM_W'(psum_s1[2]) + SUM_W'(psum_s1[3]);
	assign mean_w = sum_w[SUM_W-1 -: PIX_W];

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s2     <= px_s1;
			center_s2 <= center_s1;
			mean_s2   <= mean_w;
			hi_s2     <= HI_W'(mean_w) + HI_W'(gate_q);
			lo_s2     <= $signed(LO_W'(mean_w)) - $signed(LO_W'(gate_q));
		end
	end

	// stage 3: per-pixel band compare, center flat, start state
	logic [RING_LEN-1:0] below_w, above_w;
	always_comb begin
		for (int k = 0; k < RING_LEN; k++) begin
			below_w[k] = $signed(LO_W'(px_s2[k])) < lo_s2;
			above_w[k] = HI_W'(px_s2[k]) > hi_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			below_s3 <= below_w;
			above_s3 <= above_w;
			up0_s3   <= px_s2[RING_LEN-1] > mean_s2;
			flat_s3  <= ($signed(LO_W'(center_s2)) > lo_s2)
				&& (HI_W'(center_s2) < hi_s2);
		end
	end

	// stage 4: hysteresis walk over pixels 0..7
	logic up_a;
	logic [HCNT_W-1:0] cnt_a;
	always_comb begin
		up_a  = up0_s3;
		cnt_a = '0;
		for (int k = 0; k < HALF_RING; k++) begin
			if (up_a && below_s3[k]) begin
				up_a  = 1'b0;
				cnt_a = cnt_a + 1'b1;
			end else if (!up_a && above_s3[k]) begin
				up_a  = 1'b1;
				cnt_a = cnt_a + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			below_s4 <= below_s3[RING_LEN-1 -: HALF_RING];
			above_s4 <= above_s3[RING_LEN-1 -: HALF_RING];
			up_s4    <= up_a;
			cnt_s4   <= cnt_a;
			flat_s4  <= flat_s3;
		end
	end

	// stage 5: walk over pixels 8..15, corner decision
	logic up_b;
	logic [CNT_W-1:0] cnt_b;
	always_comb begin
		up_b  = up_s4;
		cnt_b = CNT_W'(cnt_s4);
		for (int k = 0; k < HALF_RING; k++) begin
			if (up_b && below_s4[k]) begin
				up_b  = 1'b0;
				cnt_b = cnt_b + 1'b1;
			end else if (!up_b && above_s4[k]) begin
				up_b  = 1'b1;
				cnt_b = cnt_b + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cnt_s5    <= cnt_b;
			flat_s5   <= flat_s4;
			corner_s5 <= flat_s4 && (cnt_b == CNT_W'(CORNER_SWAPS));
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = {(OUT_W - CNT_W - 2)'(0), cnt_s5, flat_s5, corner_s5};

	// checks
	a_corner_needs_four: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |->
			m_axis_tdata[1] && (m_axis_tdata[6:2] == CNT_W'(CORNER_SWAPS)))
		else $error("corner flagged without flat center and four transitions");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[6:2] <= CNT_W'(RING_LEN))
		else $error("transition count above ring length");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted word did not enter stage 1");

	a_drain_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && adv |=> m_axis_tvalid)
		else $error("stage 4 word lost on way to output");

endmodule
`default_nettype wire
